>>> rtl/rrte_pkg.sv
// ----------------------------------------------------------------------------
// rrte_pkg
// Shared types, constants and helpers for the RRT extend unit.
// ----------------------------------------------------------------------------
package rrte_pkg;

    localparam int TREE_NODES    = 1024;
    localparam int BOX_SLOTS     = 16;
    localparam int CONNECT_STEPS = 32;
    localparam int COORD_BITS    = 32;

    localparam int IDX_W     = $clog2(TREE_NODES);
    localparam int CNT_W     = $clog2(TREE_NODES + 1);
    localparam int BOX_IDX_W = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
    localparam int BOX_CNT_W = $clog2(BOX_SLOTS + 1);
    localparam int EXT_W     = $clog2(CONNECT_STEPS + 1);

    localparam int LEN_W     = 31;
    localparam int OUT_IDX_W = 10;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 2;

    // coordinate difference, squared distance, norm, divide dividend
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ROOT_W = DIFF_W;
    localparam int PROD_W = DIFF_W + LEN_W;

    localparam logic [LEN_W-1:0] STEP_LEN_RST = LEN_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT  = 2'd1;

    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_ADVANCED = 3'd1;
    localparam logic [ST_W-1:0] ST_REACHED  = 3'd2;
    localparam logic [ST_W-1:0] ST_TRAPPED  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ROOT   = 2'd1,
        CMD_EXTEND = 2'd2,
        CMD_BOX    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        K_CLEAR = 3'd0,
        K_ROOT  = 3'd1,
        K_BOX   = 3'd2,
        K_FULL  = 3'd3,
        K_EMPTY = 3'd4,
        K_TRAP  = 3'd5,
        K_NODE  = 3'd6
    } res_kind_t;

    typedef struct packed {
        cmd_t                          cmd;
        logic signed [COORD_BITS-1:0]  x_coord;
        logic signed [COORD_BITS-1:0]  y_coord;
        logic        [LEN_W-1:0]       box_width;
        logic        [LEN_W-1:0]       box_height;
    } in_item_t;

    typedef struct packed {
        logic        [ST_W-1:0]        status;
        logic signed [COORD_BITS-1:0]  new_x;
        logic signed [COORD_BITS-1:0]  new_y;
        logic        [OUT_IDX_W-1:0]   parent_index;
        logic        [OUT_IDX_W-1:0]   node_index;
        logic        [LEN_W-1:0]       step_taken;
        logic                          last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [IDX_W-1:0]      parent;
    } tree_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [LEN_W-1:0]      w;
        logic        [LEN_W-1:0]      h;
    } box_word_t;

    typedef struct packed {
        logic      scan_start;
        logic      scan_run;
        logic      sqrt_start;
        logic      tgt_sample;
        logic      mul_x;
        logic      mul_y;
        logic      div_start;
        logic      cap_ux;
        logic      cap_uy;
        logic      box_start;
        logic      box_run;
        logic      res_load;
        logic      res_last;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic tree_empty;
        logic tree_full;
        logic box_full;
        logic scan_done;
        logic sqrt_done;
        logic div_done;
        logic box_done;
        logic box_hit;
        logic reached;
        logic connect;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        coord_diff = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [DIFF_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] d);
        diff_mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

>>> rtl/rrte_sqrt.sv
// ----------------------------------------------------------------------------
// rrte_sqrt
// Digit-recurrence integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rrte_sqrt
    import rrte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int SC_W  = $clog2(ROOT_W + 1);

    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SC_W-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_t;
    logic [REM_W+1:0]  trial;
    logic              take;

    always_comb
    begin
        rem_t = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial = (REM_W + 2)'({root_reg, 2'b01});
        take  = (rem_t >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SC_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/rrte_div.sv
// ----------------------------------------------------------------------------
// rrte_div
// Restoring divider, one dividend bit per cycle; quotient known to fit.
// ----------------------------------------------------------------------------
module rrte_div
    import rrte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [ROOT_W-1:0] divisor,
    output logic              done,
    output logic [LEN_W-1:0]  quotient
);

    localparam int DC_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] dvd_reg;
    logic [ROOT_W-1:0] dsr_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [LEN_W-1:0]  q_reg;
    logic [DC_W-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W:0]   rem_t;
    logic              take;

    always_comb
    begin
        rem_t = {rem_reg, dvd_reg[PROD_W-1]};
        take  = (rem_t >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DC_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= take ? ROOT_W'(rem_t - {1'b0, dsr_reg}) : ROOT_W'(rem_t);
            q_reg   <= {q_reg[LEN_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/rrte_datapath.sv
// ----------------------------------------------------------------------------
// rrte_datapath
// Node and box stores, nearest-node scan pipeline, step math, box test,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module rrte_datapath
    import rrte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_in,
    input  in_item_t             in_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           stat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    // configuration
    logic [LEN_W-1:0] step_len_reg;
    logic             connect_reg;

    // captured command
    in_item_t         item_reg;

    // stores
    tree_word_t       tree_mem [TREE_NODES];
    tree_word_t       tree_q;
    logic [CNT_W-1:0] tree_cnt_reg;
    box_word_t        box_mem [BOX_SLOTS];
    box_word_t        box_q;
    logic [BOX_CNT_W-1:0] box_cnt_reg;

    // scan pipeline
    logic [CNT_W-1:0]  issue_idx_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic signed [COORD_BITS-1:0] x2_reg, y2_reg, x3_reg, y3_reg;
    logic [DIFF_W-1:0] mx2_reg, my2_reg;
    logic [SQ_W-1:0]   sqx3_reg, sqy3_reg;
    logic [SQ_W-1:0]   best_reg;
    logic              best_valid_reg;
    logic [IDX_W-1:0]  near_reg;
    logic signed [COORD_BITS-1:0] near_x_reg, near_y_reg;
    logic [SQ_W-1:0]   dist_sum;
    logic              issue;

    // step math
    logic [PROD_W-1:0] prod_reg;
    logic signed [COORD_BITS-1:0] tgt_x_reg, tgt_y_reg;
    logic signed [DIFF_W-1:0] ndx, ndy;
    logic [DIFF_W-1:0] nmx, nmy;
    logic              sqrt_done, div_done;
    logic [ROOT_W-1:0] norm;
    logic [LEN_W-1:0]  quot;
    logic signed [COORD_BITS-1:0] ustep;

    // box test
    logic [BOX_CNT_W-1:0] box_idx_reg;
    logic                 bv_reg;
    logic                 hit_reg;
    logic                 box_issue;
    logic                 inside_box;
    logic signed [DIFF_W-1:0] bx_hi, by_hi;

    // output
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t res;
    logic      reached;

    // -------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len_reg <= STEP_LEN_RST;
            connect_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_LEN: step_len_reg <= cfg_data;
                CFG_CONNECT:  connect_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            item_reg <= in_data;
    end

    // -------------------------------------------------------------- stores
    logic             tree_we;
    logic [IDX_W-1:0] tree_waddr;
    tree_word_t       tree_wdata;

    always_comb
    begin
        tree_we    = cmd.res_load && (cmd.res_kind == K_ROOT || cmd.res_kind == K_NODE);
        tree_waddr = tree_cnt_reg[IDX_W-1:0];
        if (cmd.res_kind == K_ROOT)
            tree_wdata = '{x: item_reg.x_coord, y: item_reg.y_coord, parent: tree_waddr};
        else
            tree_wdata = '{x: tgt_x_reg, y: tgt_y_reg, parent: near_reg};
    end

    always_ff @(posedge clk)
    begin
        if (tree_we)
            tree_mem[tree_waddr] <= tree_wdata;
        tree_q <= tree_mem[issue_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load && cmd.res_kind == K_BOX)
            box_mem[box_cnt_reg[BOX_IDX_W-1:0]] <= '{x: item_reg.x_coord,
                                                     y: item_reg.y_coord,
                                                     w: item_reg.box_width,
                                                     h: item_reg.box_height};
        box_q <= box_mem[box_idx_reg[BOX_IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_cnt_reg <= '0;
            box_cnt_reg  <= '0;
        end
        else if (cmd.res_load)
        begin
            case (cmd.res_kind)
                K_CLEAR:        tree_cnt_reg <= '0;
                K_ROOT, K_NODE: tree_cnt_reg <= tree_cnt_reg + 1'b1;
                K_BOX:          box_cnt_reg  <= box_cnt_reg + 1'b1;
                default:        ;
            endcase
        end
    end

    // -------------------------------------------------------- nearest scan
    assign issue    = cmd.scan_run && (issue_idx_reg < tree_cnt_reg);
    assign dist_sum = sqx3_reg + sqy3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg  <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            issue_idx_reg  <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                issue_idx_reg <= issue_idx_reg + 1'b1;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg)
                best_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= issue_idx_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        x2_reg   <= tree_q.x;
        y2_reg   <= tree_q.y;
        mx2_reg  <= diff_mag(coord_diff(item_reg.x_coord, tree_q.x));
        my2_reg  <= diff_mag(coord_diff(item_reg.y_coord, tree_q.y));
        idx3_reg <= idx2_reg;
        x3_reg   <= x2_reg;
        y3_reg   <= y2_reg;
        sqx3_reg <= mx2_reg * mx2_reg;
        sqy3_reg <= my2_reg * my2_reg;
        // strict compare keeps the earliest node on a tie
        if (v3_reg && (!best_valid_reg || dist_sum < best_reg))
        begin
            best_reg   <= dist_sum;
            near_reg   <= idx3_reg;
            near_x_reg <= x3_reg;
            near_y_reg <= y3_reg;
        end
    end

    // ----------------------------------------------------------- step math
    rrte_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (best_reg),
        .done     (sqrt_done),
        .root     (norm)
    );

    rrte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (norm),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        ndx     = coord_diff(item_reg.x_coord, near_x_reg);
        ndy     = coord_diff(item_reg.y_coord, near_y_reg);
        nmx     = diff_mag(ndx);
        nmy     = diff_mag(ndy);
        reached = (norm <= ROOT_W'(step_len_reg));
        ustep   = COORD_BITS'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_x)
            prod_reg <= nmx * step_len_reg;
        else if (cmd.mul_y)
            prod_reg <= nmy * step_len_reg;

        if (cmd.tgt_sample)
        begin
            tgt_x_reg <= item_reg.x_coord;
            tgt_y_reg <= item_reg.y_coord;
        end
        if (cmd.cap_ux)
            tgt_x_reg <= ndx[DIFF_W-1] ? near_x_reg - ustep : near_x_reg + ustep;
        if (cmd.cap_uy)
            tgt_y_reg <= ndy[DIFF_W-1] ? near_y_reg - ustep : near_y_reg + ustep;
    end

    // ------------------------------------------------------------ box test
    assign box_issue = cmd.box_run && (box_idx_reg < box_cnt_reg);

    always_comb
    begin
        bx_hi      = DIFF_W'(box_q.x) + DIFF_W'({1'b0, box_q.w});
        by_hi      = DIFF_W'(box_q.y) + DIFF_W'({1'b0, box_q.h});
        inside_box = (box_q.x <= tgt_x_reg) && (DIFF_W'(tgt_x_reg) <= bx_hi) &&
                     (box_q.y <= tgt_y_reg) && (DIFF_W'(tgt_y_reg) <= by_hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_idx_reg <= '0;
            bv_reg      <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else if (cmd.box_start)
        begin
            box_idx_reg <= '0;
            bv_reg      <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (box_issue)
                box_idx_reg <= box_idx_reg + 1'b1;
            bv_reg <= box_issue;
            if (bv_reg && inside_box)
                hit_reg <= 1'b1;
        end
    end

    // -------------------------------------------------------------- output
    always_comb
    begin
        res      = '0;
        res.last = cmd.res_last;
        case (cmd.res_kind)
            K_ROOT:
            begin
                res.status       = ST_DONE;
                res.new_x        = item_reg.x_coord;
                res.new_y        = item_reg.y_coord;
                res.parent_index = OUT_IDX_W'(tree_cnt_reg);
                res.node_index   = OUT_IDX_W'(tree_cnt_reg);
            end
            K_FULL:  res.status = ST_FULL;
            K_EMPTY: res.status = ST_EMPTY;
            K_TRAP:
            begin
                res.status       = ST_TRAPPED;
                res.parent_index = OUT_IDX_W'(near_reg);
            end
            K_NODE:
            begin
                res.status       = reached ? ST_REACHED : ST_ADVANCED;
                res.new_x        = tgt_x_reg;
                res.new_y        = tgt_y_reg;
                res.parent_index = OUT_IDX_W'(near_reg);
                res.node_index   = OUT_IDX_W'(tree_cnt_reg);
                res.step_taken   = reached ? LEN_W'(norm) : step_len_reg;
            end
            default: res.status = ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        stat.cmd        = item_reg.cmd;
        stat.tree_empty = (tree_cnt_reg == '0);
        stat.tree_full  = (tree_cnt_reg >= CNT_W'(TREE_NODES));
        stat.box_full   = (box_cnt_reg >= BOX_CNT_W'(BOX_SLOTS));
        stat.scan_done  = cmd.scan_run && !issue && !v1_reg && !v2_reg && !v3_reg;
        stat.sqrt_done  = sqrt_done;
        stat.div_done   = div_done;
        stat.box_done   = cmd.box_run && !box_issue && !bv_reg;
        stat.box_hit    = hit_reg;
        stat.reached    = reached;
        stat.connect    = connect_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

endmodule

>>> rtl/rrte_ctrl.sv
// ----------------------------------------------------------------------------
// rrte_ctrl
// Command sequencer: dispatch, extend steps, connect repeats, result beats.
// ----------------------------------------------------------------------------
module rrte_ctrl
    import rrte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    output logic       idle,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DISPATCH  = 15'b000000000000010,
        S_EXT_CHECK = 15'b000000000000100,
        S_SCAN      = 15'b000000000001000,
        S_SQRT_WAIT = 15'b000000000010000,
        S_MULX      = 15'b000000000100000,
        S_DIVX_GO   = 15'b000000001000000,
        S_DIVX_WAIT = 15'b000000010000000,
        S_MULY      = 15'b000000100000000,
        S_DIVY_GO   = 15'b000001000000000,
        S_DIVY_WAIT = 15'b000010000000000,
        S_BOX_GO    = 15'b000100000000000,
        S_BOX_RUN   = 15'b001000000000000,
        S_EMIT      = 15'b010000000000000,
        S_SPARE     = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    res_kind_t        kind_reg, kind_next;
    logic [EXT_W-1:0] ext_cnt_reg, ext_cnt_next;
    logic             last;

    // only an advancing extend in connect mode below the cap keeps going
    assign last = !(kind_reg == K_NODE && !stat.reached && stat.connect &&
                    ext_cnt_reg < EXT_W'(CONNECT_STEPS));

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        ext_cnt_next = ext_cnt_reg;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        cmd.res_last = last;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                state_next = S_EMIT;
                unique case (stat.cmd)
                    CMD_CLEAR: kind_next = K_CLEAR;
                    CMD_ROOT:  kind_next = stat.tree_full ? K_FULL : K_ROOT;
                    CMD_BOX:   kind_next = stat.box_full ? K_FULL : K_BOX;
                    CMD_EXTEND:
                    begin
                        ext_cnt_next = EXT_W'(1);
                        state_next   = S_EXT_CHECK;
                    end
                    default:   kind_next = K_CLEAR;
                endcase
            end
            S_EXT_CHECK:
            begin
                if (stat.tree_empty)
                begin
                    kind_next  = K_EMPTY;
                    state_next = S_EMIT;
                end
                else if (stat.tree_full)
                begin
                    kind_next  = K_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    if (stat.reached)
                    begin
                        cmd.tgt_sample = 1'b1;
                        state_next     = S_BOX_GO;
                    end
                    else
                        state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_DIVX_GO;
            end
            S_DIVX_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVX_WAIT;
            end
            S_DIVX_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_ux = 1'b1;
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_DIVY_GO;
            end
            S_DIVY_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVY_WAIT;
            end
            S_DIVY_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_uy = 1'b1;
                    state_next = S_BOX_GO;
                end
            end
            S_BOX_GO:
            begin
                cmd.box_start = 1'b1;
                state_next    = S_BOX_RUN;
            end
            S_BOX_RUN:
            begin
                cmd.box_run = 1'b1;
                if (stat.box_done)
                begin
                    kind_next  = stat.box_hit ? K_TRAP : K_NODE;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    if (last)
                        state_next = S_IDLE;
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg + 1'b1;
                        state_next   = S_EXT_CHECK;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kind_reg    <= K_CLEAR;
            ext_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            ext_cnt_reg <= ext_cnt_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

>>> rtl/rrt_tree_extend_unit.sv
// Clear, add root and add box go from dispatch straight to the result beat.
// Extend runs dispatch, tree check, node scan, root and box test before its beat;
// a clipped step adds two multiply-and-divide passes, one per axis, before the box test.
// Connect mode: each extra beat repeats the extend from the tree check, skipping dispatch.
// One command at a time; the node scan (one node per cycle) and the bit-serial
// root and divide set its length. Reset clears counts, restores config defaults.
// ----------------------------------------------------------------------------
// rrt_tree_extend_unit
// 2D RRT extend engine: node store, nearest search, clipped step, box test.
// ----------------------------------------------------------------------------
module rrt_tree_extend_unit
    import rrte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    logic       idle;
    logic       accept;
    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign in_stall  = !idle;
    assign accept    = in_valid && idle;
    assign cfg_ready = 1'b1;

    rrte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .idle   (idle),
        .stat   (stat),
        .cmd    (cmd)
    );

    rrte_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_in   (accept),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> rtl/rrte_checker.sv
// ----------------------------------------------------------------------------
// rrte_checker
// Port-level checks on the RRT extend unit, bound to the top level.
// ----------------------------------------------------------------------------
module rrte_checker
    import rrte_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result beat changed");

    // one command at a time: the next accept waits for the work to finish
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken back to back");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_EMPTY)
        else $error("status code out of range");

    // only an advancing extend is followed by more beats of the same command
    a_more_adv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.status == ST_ADVANCED)
        else $error("non-final beat is not advanced");

endmodule

bind rrt_tree_extend_unit rrte_checker u_rrte_checker (.*);
